/* hw/rtl/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV package
// Types and constants shared by the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	// Quotient width of both dividers and the number of steps in each stage.
	localparam int QW        = 13;
	localparam int STEPS     = 2;
	localparam int DIV_STGS  = (QW + STEPS - 1) / STEPS;
	localparam int NSTG      = DIV_STGS + 3;

	// Hue base per sector, offset * 64 - 3840, modulo 2^15.
	localparam logic [14:0] BASE_RED_LO  = 15'd28928;
	localparam logic [14:0] BASE_RED_HI  = 15'd19200;
	localparam logic [14:0] BASE_GREEN   = 15'd3840;
	localparam logic [14:0] BASE_BLUE    = 15'd11520;

	typedef struct packed {
		logic [21:0]   hrem;
		logic [8:0]    hdiv;
		logic [QW-1:0] hq;
		logic [20:0]   srem;
		logic [8:0]    sdiv;
		logic [QW-1:0] sq;
		logic [14:0]   hbase;
		logic          gray;
		logic          black;
		logic [7:0]    mx;
	} div_t;

	// One restoring division step for both dividers at quotient bit bit_i.
	function automatic div_t div_step(div_t x, int bit_i);
		div_t  y;
		logic [21:0] hsh;
		logic [20:0] ssh;
		y   = x;
		hsh = 22'(x.hdiv) << bit_i;
		ssh = 21'(x.sdiv) << bit_i;
		if (x.hrem >= hsh) begin
			y.hrem       = x.hrem - hsh;
			y.hq[bit_i]  = 1'b1;
		end
		if (x.srem >= ssh) begin
			y.srem       = x.srem - ssh;
			y.sq[bit_i]  = 1'b1;
		end
		return y;
	endfunction

endpackage

/* hw/rtl/rgb_to_hsv_pixel.sv */
// An accepted item passes stage 1, stage 2, the divider stages and output stage.
// Throughput: one item per cycle unless the output stalls; the two 13-bit dividers
// are split into seven stages of up to two quotient bits each, so every stage
// is busy in parallel. A stalled output holds its item, empty stages move forward.
// Reset clears only the valid bits of the stages; data registers keep values.
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts an 8-bit RGB pixel into hue (1/64 degree), saturation (1/4096)
// and brightness, with both quotients rounded to nearest.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
	import rgbhsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] hue,
	output logic [12:0] saturation,
	output logic [7:0]  brightness
);

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] adv;

	logic [7:0]  mx, mn, d, pa, pc;
	logic [8:0]  e_w;
	logic [14:0] base;

	logic [7:0]  mx_s1, d_s1;
	logic [8:0]  e_s1;
	logic [14:0] base_s1;

	div_t div_s  [0:DIV_STGS];
	div_t div_nx [1:DIV_STGS];
	div_t div_in;

	logic [14:0] hue_q;
	logic [12:0] sat_q;
	logic [7:0]  bri_q;

	// Each stage moves when it is empty or the next stage moves.
	always_comb begin
		adv[NSTG+1] = out_ready;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: extremes, sector and the shifted hue difference.
	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		d  = mx - mn;
		if (mx == blue) begin
			pa   = red;
			pc   = green;
			base = BASE_BLUE;
		end else if (mx == green) begin
			pa   = blue;
			pc   = red;
			base = BASE_GREEN;
		end else if (green >= blue) begin
			pa   = green;
			pc   = blue;
			base = BASE_RED_LO;
		end else begin
			pa   = green;
			pc   = blue;
			base = BASE_RED_HI;
		end
		e_w = {1'b0, d} + {1'b0, pa} - {1'b0, pc};
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mx_s1   <= mx;
			d_s1    <= d;
			e_s1    <= e_w;
			base_s1 <= base;
		end
	end

	// Stage 2: dividends and divisors with the rounding half folded in.
	always_comb begin
		div_in.hrem  = ({e_s1, 13'b0} - {4'b0, e_s1, 9'b0}) + {14'b0, d_s1};
		div_in.hdiv  = {d_s1, 1'b0};
		div_in.hq    = '0;
		div_in.srem  = {d_s1, 5'b0, mx_s1};
		div_in.sdiv  = {mx_s1, 1'b0};
		div_in.sq    = '0;
		div_in.hbase = base_s1;
		div_in.gray  = (d_s1 == 8'd0);
		div_in.black = (mx_s1 == 8'd0);
		div_in.mx    = mx_s1;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			div_s[0] <= div_in;
		end
	end

	// Divider stages.
	for (genvar j = 1; j <= DIV_STGS; j++) begin : g_div
		always_comb begin
			div_nx[j] = div_s[j-1];
			for (int t = 0; t < STEPS; t++) begin
				if (QW - 1 - STEPS * (j - 1) - t >= 0) begin
					div_nx[j] = div_step(div_nx[j], QW - 1 - STEPS * (j - 1) - t);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j+2]) begin
				div_s[j] <= div_nx[j];
			end
		end
	end

	// Output stage.
	always_ff @(posedge clk) begin
		if (adv[NSTG]) begin
			hue_q <= div_s[DIV_STGS].gray ? 15'd0
				: div_s[DIV_STGS].hbase + 15'(div_s[DIV_STGS].hq);
			sat_q <= div_s[DIV_STGS].black ? 13'd0 : div_s[DIV_STGS].sq;
			bri_q <= div_s[DIV_STGS].mx;
		end
	end

	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bri_q;

	// The input is held off only behind a stalled output item.
	a_ready_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a stalled output item");

	a_black : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && brightness == 8'd0) |-> (hue == 15'd0 && saturation == 13'd0))
		else $error("black pixel with nonzero hue or saturation");

	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue < 15'd23040 && saturation <= 13'd4096))
		else $error("hue or saturation out of range");

	a_fill : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_ready) |=> vld_q[1])
		else $error("accepted item missing from the first stage");

endmodule
